// ===== design/qcp_pkg.sv =====
// ============================================================================
// qcp_pkg : quaternion chain product package
// Shared widths, beat types and the exact wide product helper.
// ============================================================================
package qcp_pkg;

    localparam int COMP_W        = 32;
    localparam int FRAC_BITS_DEF = 16;
    // Four exact 64-bit products added together need two extra bits.
    localparam int SUM_W         = 2 * COMP_W + 2;

    typedef logic signed [COMP_W-1:0] comp_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    typedef struct packed {
        logic  first;
        comp_t comp_w;
        comp_t comp_x;
        comp_t comp_y;
        comp_t comp_z;
    } item_t;

    typedef struct packed {
        comp_t prod_w;
        comp_t prod_x;
        comp_t prod_y;
        comp_t prod_z;
        logic  saturated;
    } result_t;

    // Full-precision signed product, sign extended to the sum width.
    function automatic sum_t mul_ext(comp_t a, comp_t b);
        logic signed [2*COMP_W-1:0] p;
        p = a * b;
        return {{(SUM_W-2*COMP_W){p[2*COMP_W-1]}}, p};
    endfunction

endpackage

// ===== design/quaternion_chain_product.sv =====
// ============================================================================
// quaternion_chain_product : running Hamilton product of a quaternion stream
// Loads or multiplies the running product per beat, emits it every beat.
// ============================================================================
// Each input beat carries a quaternion in signed fixed point (FRAC_BITS
// fraction bits, Q16.16 by default) and a first flag. A first beat loads the
// running product with its quaternion; any other beat replaces it with
// product * q (stored value on the left). Every beat returns the product as
// it stands after the update, so r*p*q is three beats: r with first set, then
// p, then q. Each component is the exact sum of four 32x32 products, shifted
// arithmetically right by FRAC_BITS (rounds toward minus infinity) and
// clipped to 32 bits; saturated flags a beat on which any component clipped.
// After reset the product is the identity quaternion. Throughput is one beat
// per clock with no bubbles while results are taken; a stalled result holds
// the flow. The beat sits in an input register, then one pass of sixteen
// parallel 32x32 multipliers, four adder trees and the clip logic writes the
// product register, which is also the result register. That loop from the
// product register back into itself is the critical path. Ready toward the
// input stays high whenever the result register is empty or being taken.
// ============================================================================
module quaternion_chain_product
    import qcp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    // identity scalar part, 1.0 in the chosen format
    localparam comp_t ONE_Q   = comp_t'(longint'(1) << FRAC_BITS);
    localparam sum_t  SAT_MAX = sum_t'(comp_t'({1'b0, {(COMP_W-1){1'b1}}}));
    localparam sum_t  SAT_MIN = sum_t'(comp_t'({1'b1, {(COMP_W-1){1'b0}}}));

    // input stage
    logic  s1_valid_reg, s1_valid_next;
    item_t s1_item_reg;

    // product / result stage
    logic  out_valid_reg, out_valid_next;
    comp_t acc_w_reg, acc_w_next;
    comp_t acc_x_reg, acc_x_next;
    comp_t acc_y_reg, acc_y_next;
    comp_t acc_z_reg, acc_z_next;
    logic  sat_reg, sat_next;

    logic  advance;
    logic  load_s1;
    logic  update;

    sum_t  sum_w, sum_x, sum_y, sum_z;
    logic [COMP_W:0] clip_w, clip_x, clip_y, clip_z;

    // Shift and clip; bit COMP_W of the result is the clip flag.
    function automatic logic [COMP_W:0] clip(sum_t s);
        sum_t sh;
        sh = s >>> FRAC_BITS;
        if (sh > SAT_MAX)
        begin
            return {1'b1, SAT_MAX[COMP_W-1:0]};
        end
        else if (sh < SAT_MIN)
        begin
            return {1'b1, SAT_MIN[COMP_W-1:0]};
        end
        return {1'b0, sh[COMP_W-1:0]};
    endfunction

    // ---- handshake ---------------------------------------------------------
    // The result register frees up when empty or taken this cycle; the input
    // register moves on with it, so a beat enters every cycle the result is free.
    assign advance    = !out_valid_reg || result_ready;
    assign item_ready = !s1_valid_reg || advance;
    assign load_s1    = item_valid && item_ready;
    assign update     = advance && s1_valid_reg;

    // ---- Hamilton product: stored value p on the left, new beat q right ----
    always_comb
    begin
        sum_w = mul_ext(acc_w_reg, s1_item_reg.comp_w)
              - mul_ext(acc_x_reg, s1_item_reg.comp_x)
              - mul_ext(acc_y_reg, s1_item_reg.comp_y)
              - mul_ext(acc_z_reg, s1_item_reg.comp_z);
        sum_x = mul_ext(acc_w_reg, s1_item_reg.comp_x)
              + mul_ext(acc_x_reg, s1_item_reg.comp_w)
              + mul_ext(acc_y_reg, s1_item_reg.comp_z)
              - mul_ext(acc_z_reg, s1_item_reg.comp_y);
        sum_y = mul_ext(acc_w_reg, s1_item_reg.comp_y)
              - mul_ext(acc_x_reg, s1_item_reg.comp_z)
              + mul_ext(acc_y_reg, s1_item_reg.comp_w)
              + mul_ext(acc_z_reg, s1_item_reg.comp_x);
        sum_z = mul_ext(acc_w_reg, s1_item_reg.comp_z)
              + mul_ext(acc_x_reg, s1_item_reg.comp_y)
              - mul_ext(acc_y_reg, s1_item_reg.comp_x)
              + mul_ext(acc_z_reg, s1_item_reg.comp_w);
    end

    assign clip_w = clip(sum_w);
    assign clip_x = clip(sum_x);
    assign clip_y = clip(sum_y);
    assign clip_z = clip(sum_z);

    // ---- next-state logic --------------------------------------------------
    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        acc_w_next     = acc_w_reg;
        acc_x_next     = acc_x_reg;
        acc_y_next     = acc_y_reg;
        acc_z_next     = acc_z_reg;
        sat_next       = sat_reg;

        if (item_ready)
        begin
            s1_valid_next = item_valid;
        end
        if (advance)
        begin
            out_valid_next = s1_valid_reg;
        end
        if (update)
        begin
            if (s1_item_reg.first)
            begin
                // new chain: load the beat as is, nothing can clip
                acc_w_next = s1_item_reg.comp_w;
                acc_x_next = s1_item_reg.comp_x;
                acc_y_next = s1_item_reg.comp_y;
                acc_z_next = s1_item_reg.comp_z;
                sat_next   = 1'b0;
            end
            else
            begin
                acc_w_next = clip_w[COMP_W-1:0];
                acc_x_next = clip_x[COMP_W-1:0];
                acc_y_next = clip_y[COMP_W-1:0];
                acc_z_next = clip_z[COMP_W-1:0];
                sat_next   = clip_w[COMP_W] | clip_x[COMP_W]
                           | clip_y[COMP_W] | clip_z[COMP_W];
            end
        end
    end

    // ---- registers ---------------------------------------------------------
    // Product is state: it resets to the identity quaternion.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_w_reg     <= ONE_Q;
            acc_x_reg     <= '0;
            acc_y_reg     <= '0;
            acc_z_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            acc_w_reg     <= acc_w_next;
            acc_x_reg     <= acc_x_next;
            acc_y_reg     <= acc_y_next;
            acc_z_reg     <= acc_z_next;
        end
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        if (load_s1)
        begin
            s1_item_reg <= item;
        end
        sat_reg <= sat_next;
    end

    // ---- result beat -------------------------------------------------------
    // The product register doubles as the result register; it only changes
    // when the result register is free, so a stalled beat holds.
    assign result_valid     = out_valid_reg;
    assign result.prod_w    = acc_w_reg;
    assign result.prod_x    = acc_x_reg;
    assign result.prod_y    = acc_y_reg;
    assign result.prod_z    = acc_z_reg;
    assign result.saturated = sat_reg;

endmodule

// ===== design/qcp_checker.sv =====
// ============================================================================
// qcp_checker : port-level checks for the quaternion chain product
// Watches the top-level ports only; bound to every instance.
// ============================================================================
module qcp_checker
    import qcp_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_ready,
    input item_t   item,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result
);

    localparam comp_t Q_MAX = comp_t'({1'b0, {(COMP_W-1){1'b1}}});
    localparam comp_t Q_MIN = comp_t'({1'b1, {(COMP_W-1){1'b0}}});

    logic in_beat;
    assign in_beat = item_valid && item_ready;

    // a stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    // input never stalls while the output side can move
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid || result_ready |-> item_ready)
        else $error("input stalled with result side free");

    // a first beat into an empty pipe comes out of the product register unchanged
    a_first_load: assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && item.first && !result_valid) ##1 (!result_valid || result_ready)
        |=> result_valid
            && result.prod_w == $past(item.comp_w, 2)
            && result.prod_x == $past(item.comp_x, 2)
            && result.prod_y == $past(item.comp_y, 2)
            && result.prod_z == $past(item.comp_z, 2)
            && !result.saturated)
        else $error("first beat not loaded as is");

    // a clipped beat shows at least one component at a rail
    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.saturated
        |-> result.prod_w == Q_MAX || result.prod_w == Q_MIN
         || result.prod_x == Q_MAX || result.prod_x == Q_MIN
         || result.prod_y == Q_MAX || result.prod_y == Q_MIN
         || result.prod_z == Q_MAX || result.prod_z == Q_MIN)
        else $error("saturated set with no component at a rail");

endmodule

bind quaternion_chain_product qcp_checker u_qcp_checker (.*);

// ===== tb/tb_quaternion_chain_product.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_quaternion_chain_product : self-checking bench for the quaternion chain
// Streams chained quaternion beats through the block under bursty input and
// a stalling output. Every result beat is checked against a running Hamilton
// product kept here at full width, floored by the fraction shift and clipped.
// ============================================================================
module tb_quaternion_chain_product;
    import qcp_pkg::*;

    localparam int FRAC       = FRAC_BITS_DEF;
    localparam int CYCLE_CAP  = 200000;
    localparam int RAND_BEATS = 400;

    localparam comp_t Q_MAX = 32'sh7FFFFFFF;
    localparam comp_t Q_MIN = 32'sh80000000;
    localparam comp_t Q_ONE = comp_t'(1) <<< FRAC;

    // Exact width of four summed 32x32 products.
    typedef logic signed [65:0] wide_t;
    localparam wide_t CLIP_HI = (66'sd1 <<< 31) - 66'sd1;
    localparam wide_t CLIP_LO = -(66'sd1 <<< 31);

    typedef enum {VK_UNIT, VK_MID, VK_FULL, VK_EDGE} val_kind_t;
    typedef enum {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_BLOCKED} stall_mode_t;

    // One queued input beat; drain holds it back until every result is back.
    typedef struct {
        item_t beat;
        bit    drain;
    } pend_t;

    logic    clk;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_ready;
    item_t   item = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;

    pend_t   pending_beats[$];
    result_t expected_products[$];

    // Running product as the block should hold it; identity after reset.
    comp_t run_w = Q_ONE;
    comp_t run_x = '0;
    comp_t run_y = '0;
    comp_t run_z = '0;

    int          fault_count = 0;
    int          cycle_cnt   = 0;
    int          burst_left  = 1;
    int          gap_left    = 0;
    int          stall_tick  = 0;
    stall_mode_t stall_mode  = RDY_ALWAYS;

    quaternion_chain_product i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Hamilton product predictor
    // ------------------------------------------------------------------------
    function automatic wide_t full_product(comp_t a, comp_t b);
        wide_t ea;
        wide_t eb;
        ea = a;
        eb = b;
        return ea * eb;
    endfunction

    // Floor shift by the fraction width, then clip; bit 32 flags a clip.
    function automatic logic [32:0] scale_clip(wide_t s);
        wide_t t;
        t = s >>> FRAC;
        if (t > CLIP_HI)
            return {1'b1, Q_MAX};
        else if (t < CLIP_LO)
            return {1'b1, Q_MIN};
        return {1'b0, t[31:0]};
    endfunction

    // Updates the running product with one accepted beat, returns its result.
    function automatic result_t advance_product(item_t b);
        result_t     r;
        logic [32:0] cw;
        logic [32:0] cx;
        logic [32:0] cy;
        logic [32:0] cz;
        r = '0;
        if (b.first)
        begin
            // start of chain: plain load, never clips
            run_w = b.comp_w;
            run_x = b.comp_x;
            run_y = b.comp_y;
            run_z = b.comp_z;
        end
        else
        begin
            // stored product on the left, new quaternion on the right
            cw = scale_clip(full_product(run_w, b.comp_w) - full_product(run_x, b.comp_x)
                          - full_product(run_y, b.comp_y) - full_product(run_z, b.comp_z));
            cx = scale_clip(full_product(run_w, b.comp_x) + full_product(run_x, b.comp_w)
                          + full_product(run_y, b.comp_z) - full_product(run_z, b.comp_y));
            cy = scale_clip(full_product(run_w, b.comp_y) - full_product(run_x, b.comp_z)
                          + full_product(run_y, b.comp_w) + full_product(run_z, b.comp_x));
            cz = scale_clip(full_product(run_w, b.comp_z) + full_product(run_x, b.comp_y)
                          - full_product(run_y, b.comp_x) + full_product(run_z, b.comp_w));
            run_w = cw[31:0];
            run_x = cx[31:0];
            run_y = cy[31:0];
            run_z = cz[31:0];
            r.saturated = cw[32] | cx[32] | cy[32] | cz[32];
        end
        r.prod_w = run_w;
        r.prod_x = run_x;
        r.prod_y = run_y;
        r.prod_z = run_z;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_beat(input logic first, input comp_t w, input comp_t x,
                             input comp_t y, input comp_t z, input bit drain);
        pend_t p;
        p.beat.first  = first;
        p.beat.comp_w = w;
        p.beat.comp_x = x;
        p.beat.comp_y = y;
        p.beat.comp_z = z;
        p.drain       = drain;
        pending_beats.push_back(p);
    endtask

    function automatic comp_t rand_comp(val_kind_t kind);
        comp_t v;
        case (kind)
            // around +-1.0, keeps long chains inside range
            VK_UNIT: v = int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE;
            VK_MID:  v = int'($urandom_range(0, 1 << 21)) - (1 << 20);
            VK_FULL: v = $urandom;
            default:
            begin
                case ($urandom_range(0, 5))
                    0:       v = Q_MAX;
                    1:       v = Q_MIN;
                    2:       v = '0;
                    3:       v = -1;
                    4:       v = 1;
                    default: v = Q_ONE;
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            fault_count++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: bursts of beats with random gaps, one NBA per signal per edge
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : drive_proc
        logic  nxt_valid;
        item_t nxt_item;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            nxt_valid = item_valid;
            nxt_item  = item;
            if (item_valid && item_ready)
            begin
                expected_products.push_back(advance_product(item));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (pending_beats.size() > 0 &&
                         !(pending_beats[0].drain && expected_products.size() != 0))
                begin
                    nxt_item  = pending_beats[0].beat;
                    nxt_valid = 1'b1;
                    void'(pending_beats.pop_front());
                    if (burst_left > 1)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        // now and then a long burst with no gaps at all
                        burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
                        gap_left   = $urandom_range(0, 8);
                    end
                end
            end
            item_valid <= nxt_valid;
            item       <= nxt_item;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks result beats and drives the output stall pattern
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_proc
        result_t want;
        logic    nxt_ready;
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_products.size() == 0)
                begin
                    fault_count++;
                    $error("result beat with no expected product pending");
                end
                else
                begin
                    want = expected_products.pop_front();
                    check_field("prod_w", want.prod_w, result.prod_w);
                    check_field("prod_x", want.prod_x, result.prod_x);
                    check_field("prod_y", want.prod_y, result.prod_y);
                    check_field("prod_z", want.prod_z, result.prod_z);
                    check_field("saturated", want.saturated, result.saturated);
                end
            end

            // stall pattern is redrawn at random from the four modes
            stall_tick++;
            if (stall_tick % 50 == 0)
                stall_mode = stall_mode_t'($urandom_range(0, 3));
            case (stall_mode)
                RDY_ALWAYS: nxt_ready = 1'b1;
                RDY_COIN:   nxt_ready = 1'($urandom_range(0, 1));
                RDY_SPARSE: nxt_ready = (stall_tick % 6 == 0);
                default:    nxt_ready = (stall_tick % 20 >= 15);
            endcase
            result_ready <= nxt_ready;
        end
    end

    // Hard stop if the handshakes hang.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_CAP)
        begin
            $display("tb_quaternion_chain_product: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_proc
        int        sent;
        int        chain_len;
        val_kind_t kind;
        int        pick;

        // No start after reset: multiplies onto the identity.
        push_beat(1'b0, 229376, -147456, 8192, -458752, 1'b0);
        push_beat(1'b0, 32'sh12345678, -32'sh0FEDCBA9, 32'sh00C0FFEE, -3, 1'b0);
        // Extremes, both clipping directions.
        push_beat(1'b1, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b0);
        push_beat(1'b0, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b0);
        push_beat(1'b1, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b0);
        push_beat(1'b0, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b0);
        // Zero product stays zero.
        push_beat(1'b1, 0, 0, 0, 0, 1'b0);
        push_beat(1'b0, Q_MAX, Q_MIN, -1, 1, 1'b0);
        // Shift rounds toward minus infinity: -lsb * lsb-scale, then lsb * lsb.
        push_beat(1'b1, -1, 0, 0, 0, 1'b0);
        push_beat(1'b0, 1, 0, 0, 0, 1'b0);
        push_beat(1'b1, 1, 0, 0, 0, 1'b0);
        push_beat(1'b0, 1, 0, 0, 0, 1'b0);
        // Unit axes: i*j = k, then k*k = -1.
        push_beat(1'b1, 0, Q_ONE, 0, 0, 1'b0);
        push_beat(1'b0, 0, 0, Q_ONE, 0, 1'b0);
        push_beat(1'b0, 0, 0, 0, Q_ONE, 1'b0);
        // Rotation r*p*q with 45-degree-ish halves.
        push_beat(1'b1, 46341, 46341, 0, 0, 1'b0);
        push_beat(1'b0, 46341, 0, 46341, 0, 1'b0);
        push_beat(1'b0, 46341, 0, 0, -46341, 1'b0);
        // Mixed extremes per component.
        push_beat(1'b1, Q_MAX, Q_MIN, 0, -1, 1'b0);
        push_beat(1'b0, Q_MIN, Q_MAX, -1, 0, 1'b0);
        push_beat(1'b1, -Q_ONE, Q_ONE, -Q_ONE, Q_ONE, 1'b1);

        // Random chains, mostly well-formed; some run on without a start.
        sent = 0;
        while (sent < RAND_BEATS)
        begin
            pick = $urandom_range(0, 9);
            kind = (pick <= 5) ? VK_UNIT : (pick <= 7) ? VK_MID :
                   (pick == 8) ? VK_FULL : VK_EDGE;
            chain_len = $urandom_range(1, 8);
            for (int k = 0; k < chain_len; k++)
            begin
                push_beat((k == 0) ? ($urandom_range(0, 6) != 0) : 1'b0,
                          rand_comp(kind), rand_comp(kind), rand_comp(kind), rand_comp(kind),
                          (sent == 0) || ($urandom_range(0, 60) == 0));
                sent++;
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (pending_beats.size() != 0 || item_valid || expected_products.size() != 0);
        repeat (8) @(posedge clk);

        if (fault_count == 0)
            $display("tb_quaternion_chain_product: done, clean");
        else
            $display("tb_quaternion_chain_product: done, errors");
        $finish;
    end

endmodule

// ===== quaternion_chain_product.f =====
design/qcp_pkg.sv
design/quaternion_chain_product.sv
design/qcp_checker.sv
tb/tb_quaternion_chain_product.sv
